### rtl/indexed_min_heap_queue_core_macros.svh
// Assertion macros shared by the indexed min-heap queue checkers.
`ifndef INDEXED_MIN_HEAP_QUEUE_CORE_MACROS_SVH
`define INDEXED_MIN_HEAP_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, sampled on i_clk and disabled during reset.
`define IMHQ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("indexed min-heap queue assertion failed");

// Next-cycle implication, sampled on i_clk and disabled during reset.
`define IMHQ_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("indexed min-heap queue assertion failed");

`endif

### rtl/imhq_pkg.sv
// Types and codes of the indexed min-heap priority queue.
package imhq_pkg;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_DROP  = 2'd2;

    typedef struct packed {
        logic               operation;
        logic [7:0]         key_id;
        logic signed [31:0] new_weight;
    } t_in_item;

    typedef struct packed {
        logic [7:0]         out_key;
        logic signed [31:0] out_weight;
        logic [1:0]         status;
        logic               now_empty;
    } t_out_item;

endpackage

### rtl/imhq_heap_ram.sv
// Heap slot memory: one write port and two registered read ports.
module imhq_heap_ram #(
    parameter int DEPTH = 64,
    parameter int DW    = 40
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DW-1:0]            i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic [DW-1:0]            o_rd_data_a,
    output logic [DW-1:0]            o_rd_data_b
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data_a <= r_mem[i_rd_addr_a];
        o_rd_data_b <= r_mem[i_rd_addr_b];
    end

endmodule

### rtl/indexed_min_heap_queue_core.sv
// Indexed binary min-heap priority queue keyed by small key ids.
// An insert adds the key at the tail and sifts it up; an update of a present key sifts it
// up or down, or ends at once with the weight unchanged. A dequeue moves the tail entry
// to the root and sifts it down; an empty or last-entry dequeue and a dropped insert
// move no entries. One operation at a time; a new transfer is taken in the strobe cycle.
// Synchronous reset clears the entry count and presence bits; memories keep contents.
module indexed_min_heap_queue_core #(
    parameter int CAPACITY    = 64,
    parameter int KEY_COUNT   = 256,
    parameter int WEIGHT_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  imhq_pkg::t_in_item  i_item,
    output logic                o_valid,
    output imhq_pkg::t_out_item o_result
);

    localparam int PW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = $clog2(KEY_COUNT);
    localparam int EW = KW + WEIGHT_BITS;
    localparam logic signed [31:0] WMAX32 =
        32'((64'sd1 << (WEIGHT_BITS - 1)) - 64'sd1);
    localparam logic signed [31:0] WMIN32 = ~WMAX32;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_ENQ    = 4'd1;
    localparam logic [3:0] S_UPD    = 4'd2;
    localparam logic [3:0] S_DEQ    = 4'd3;
    localparam logic [3:0] S_UP_RD  = 4'd4;
    localparam logic [3:0] S_UP_CMP = 4'd5;
    localparam logic [3:0] S_DN_RD  = 4'd6;
    localparam logic [3:0] S_DN_CMP = 4'd7;
    localparam logic [3:0] S_PLACE  = 4'd8;

    logic [3:0]                    r_state, n_state;
    logic [CW-1:0]                 r_count, n_count;
    logic                          r_valid, n_valid;
    logic                          r_present [KEY_COUNT];
    logic                          set_present, clr_present;
    logic [KW-1:0]                 present_idx;

    logic [PW-1:0]                 r_pos, n_pos;
    logic [KW-1:0]                 r_cur_key, n_cur_key;
    logic signed [WEIGHT_BITS-1:0] r_cur_w, n_cur_w;
    logic                          r_bad, n_bad;
    imhq_pkg::t_out_item           r_res, n_res;

    logic signed [WEIGHT_BITS-1:0] in_w_sat;

    logic [PW-1:0]                 r_posmem [KEY_COUNT];
    logic [PW-1:0]                 r_pos_rd;
    logic                          pos_we;
    logic [KW-1:0]                 pos_waddr;
    logic [PW-1:0]                 pos_wdata;

    logic                          heap_we;
    logic [PW-1:0]                 heap_waddr, rd_addr_a, rd_addr_b;
    logic [EW-1:0]                 heap_wdata, rd_data_a, rd_data_b;
    logic [KW-1:0]                 a_key, b_key;
    logic signed [WEIGHT_BITS-1:0] a_w, b_w, best_w;

    logic [CW:0]                   l_idx, r_idx, cnt_ext;
    logic                          l_ok, r_ok, pick_l, pick_r;
    logic [PW-1:0]                 parent;

    imhq_heap_ram #(
        .DEPTH (CAPACITY),
        .DW    (EW)
    ) u_heap (
        .i_clk       (i_clk),
        .i_wr_en     (heap_we),
        .i_wr_addr   (heap_waddr),
        .i_wr_data   (heap_wdata),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_a (rd_data_a),
        .o_rd_data_b (rd_data_b)
    );

    always_comb begin
        if (WEIGHT_BITS < 32) begin
            if (i_item.new_weight > WMAX32) begin
                in_w_sat = WEIGHT_BITS'(WMAX32);
            end else if (i_item.new_weight < WMIN32) begin
                in_w_sat = WEIGHT_BITS'(WMIN32);
            end else begin
                in_w_sat = WEIGHT_BITS'(i_item.new_weight);
            end
        end else begin
            in_w_sat = WEIGHT_BITS'(i_item.new_weight);
        end
    end

    assign a_key   = rd_data_a[EW-1 -: KW];
    assign b_key   = rd_data_b[EW-1 -: KW];
    assign a_w     = signed'(rd_data_a[WEIGHT_BITS-1:0]);
    assign b_w     = signed'(rd_data_b[WEIGHT_BITS-1:0]);
    assign l_idx   = (CW + 1)'({r_pos, 1'b1});
    assign r_idx   = l_idx + 1'b1;
    assign cnt_ext = (CW + 1)'(r_count);
    assign l_ok    = l_idx < cnt_ext;
    assign r_ok    = r_idx < cnt_ext;
    assign parent  = PW'((r_pos - 1'b1) >> 1);

    always_comb begin
        pick_l = 1'b0;
        pick_r = 1'b0;
        best_w = r_cur_w;
        if (l_ok && (a_w < best_w)) begin
            pick_l = 1'b1;
            best_w = a_w;
        end
        if (r_ok && (b_w < best_w)) begin
            pick_l = 1'b0;
            pick_r = 1'b1;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_valid     = 1'b0;
        n_pos       = r_pos;
        n_cur_key   = r_cur_key;
        n_cur_w     = r_cur_w;
        n_bad       = r_bad;
        n_res       = r_res;
        set_present = 1'b0;
        clr_present = 1'b0;
        present_idx = r_cur_key;
        heap_we     = 1'b0;
        heap_waddr  = r_pos;
        heap_wdata  = {r_cur_key, r_cur_w};
        pos_we      = 1'b0;
        pos_waddr   = r_cur_key;
        pos_wdata   = r_pos;
        rd_addr_a   = '0;
        rd_addr_b   = PW'(r_count - 1'b1);
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_res.out_key    = i_item.key_id;
                    n_res.out_weight = '0;
                    n_res.status     = imhq_pkg::ST_OK;
                    n_res.now_empty  = 1'b0;
                    n_cur_key        = KW'(i_item.key_id);
                    n_cur_w          = in_w_sat;
                    n_bad            = int'(i_item.key_id) >= KEY_COUNT;
                    n_state = (i_item.operation == imhq_pkg::OP_DEQ) ? S_DEQ : S_ENQ;
                end
            end
            S_ENQ: begin
                if (r_bad) begin
                    n_res.status = imhq_pkg::ST_DROP;
                    n_valid      = 1'b1;
                end else if (r_present[r_cur_key]) begin
                    n_pos     = r_pos_rd;
                    rd_addr_a = r_pos_rd;
                    n_state   = S_UPD;
                end else if (r_count >= CW'(CAPACITY)) begin
                    n_res.status = imhq_pkg::ST_DROP;
                    n_valid      = 1'b1;
                end else begin
                    set_present = 1'b1;
                    n_count     = r_count + 1'b1;
                    n_pos       = PW'(r_count);
                    n_state     = S_UP_RD;
                end
            end
            S_UPD: begin
                if (r_cur_w < a_w) begin
                    n_state = S_UP_RD;
                end else if (r_cur_w > a_w) begin
                    n_state = S_DN_RD;
                end else begin
                    n_valid = 1'b1;
                end
            end
            S_UP_RD: begin
                rd_addr_a = parent;
                n_state   = (r_pos == '0) ? S_PLACE : S_UP_CMP;
            end
            S_UP_CMP: begin
                if (r_cur_w < a_w) begin
                    heap_we    = 1'b1;
                    heap_wdata = rd_data_a;
                    pos_we     = 1'b1;
                    pos_waddr  = a_key;
                    n_pos      = parent;
                    n_state    = S_UP_RD;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_DN_RD: begin
                rd_addr_a = PW'(l_idx);
                rd_addr_b = PW'(r_idx);
                n_state   = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (pick_l || pick_r) begin
                    heap_we    = 1'b1;
                    heap_wdata = pick_r ? rd_data_b : rd_data_a;
                    pos_we     = 1'b1;
                    pos_waddr  = pick_r ? b_key : a_key;
                    n_pos      = pick_r ? PW'(r_idx) : PW'(l_idx);
                    n_state    = S_DN_RD;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_DEQ: begin
                if (r_count == '0) begin
                    n_res.status = imhq_pkg::ST_EMPTY;
                    n_valid      = 1'b1;
                end else begin
                    n_res.out_key    = 8'(a_key);
                    n_res.out_weight = 32'(a_w);
                    clr_present      = 1'b1;
                    present_idx      = a_key;
                    n_count          = r_count - 1'b1;
                    if (r_count == CW'(1)) begin
                        n_valid = 1'b1;
                    end else begin
                        n_cur_key = b_key;
                        n_cur_w   = b_w;
                        n_pos     = '0;
                        n_state   = S_DN_RD;
                    end
                end
            end
            S_PLACE: begin
                heap_we = 1'b1;
                pos_we  = 1'b1;
                n_valid = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (n_valid) begin
            n_state         = S_IDLE;
            n_res.now_empty = (n_count == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
            for (int i = 0; i < KEY_COUNT; i++) begin
                r_present[i] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
            if (set_present) begin
                r_present[present_idx] <= 1'b1;
            end else if (clr_present) begin
                r_present[present_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_cur_key <= n_cur_key;
        r_cur_w   <= n_cur_w;
        r_bad     <= n_bad;
        r_res     <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (pos_we) begin
            r_posmem[pos_waddr] <= pos_wdata;
        end
        r_pos_rd <= r_posmem[KW'(i_item.key_id)];
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_res;

endmodule

### rtl/imhq_checker.sv
// Port-level checker for the indexed min-heap queue, bound to the top level.
`include "indexed_min_heap_queue_core_macros.svh"

module imhq_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input imhq_pkg::t_in_item  i_item,
    input logic                o_valid,
    input imhq_pkg::t_out_item o_result
);

    logic empty_res;

    assign empty_res = o_valid && (o_result.status == imhq_pkg::ST_EMPTY);

    `IMHQ_ASSERT_NXT(a_accept_busy, start && !busy, busy)
    `IMHQ_ASSERT_IMP(a_result_idle, o_valid, !busy)
    `IMHQ_ASSERT_IMP(a_result_after_work, o_valid, $past(busy))
    `IMHQ_ASSERT_IMP(a_empty_report, empty_res, o_result.out_weight == 32'sd0 && o_result.now_empty)

endmodule

bind indexed_min_heap_queue_core imhq_checker u_imhq_checker (.*);
